// ===== rtl/dmm_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and widths of the dense matrix multiply unit
package dmm_pkg;

   localparam int unsigned MAX_DIM_DEFAULT = 8;

   // field widths
   localparam int unsigned OPC_W   = 2;
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned VAL_W   = 16;
   localparam int unsigned PROD_W  = 2 * VAL_W;
   localparam int unsigned ELEM_W  = 35;
   localparam int unsigned SUM_W   = 41;
   localparam int unsigned DIM_W   = 4;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = DIM_W;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

   typedef enum logic [OPC_W-1:0] {
      OP_LOAD_A   = 2'd0,
      OP_LOAD_B   = 2'd1,
      OP_MULTIPLY = 2'd2
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_A_ROWS    = 2'd0,
      REG_INNER_DIM = 2'd1,
      REG_B_COLS    = 2'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic             wr_a;
      logic             wr_b;
      logic             rd_en;
      logic [DIM_W-1:0] i;
      logic [DIM_W-1:0] j;
      logic [DIM_W-1:0] t;
      logic             clr_acc;
      logic             clr_total;
      logic             push;
      logic             last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/dmm_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer of the dense matrix multiply unit: config registers, fsm, loop counters
module dmm_ctrl #(
   parameter int unsigned MAX_DIM = dmm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [dmm_pkg::OPC_W-1:0]          req_opcode,
   input  logic [dmm_pkg::IDX_W-1:0]          req_row,
   input  logic [dmm_pkg::IDX_W-1:0]          req_col,
   input  logic                               csr_write_enable,
   input  logic [dmm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dmm_pkg::CSR_DATA_W-1:0]     csr_data,
   output dmm_pkg::cmd_type                   cmd,
   input  dmm_pkg::status_type                status
);

   localparam int unsigned DIM_W = dmm_pkg::DIM_W;

   dmm_pkg::state_type state_ff, state_in;

   logic [DIM_W-1:0] a_rows_ff, inner_dim_ff, b_cols_ff;
   logic [DIM_W-1:0] i_ff, i_in, j_ff, j_in, t_ff, t_in;
   logic [DIM_W-1:0] m_dim, k_dim, n_dim;
   logic             accept;
   logic             start;
   logic             k_done;
   logic             elem_last;
   logic             row_end;

   // dimensions saturate at the store size
   assign m_dim = (32'(a_rows_ff) > MAX_DIM)    ? DIM_W'(MAX_DIM) : a_rows_ff;
   assign k_dim = (32'(inner_dim_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : inner_dim_ff;
   assign n_dim = (32'(b_cols_ff) > MAX_DIM)    ? DIM_W'(MAX_DIM) : b_cols_ff;

   assign accept    = req_valid && (state_ff == dmm_pkg::ST_IDLE);
   assign start     = accept && (dmm_pkg::opcode_type'(req_opcode) == dmm_pkg::OP_MULTIPLY)
                      && (m_dim != '0) && (n_dim != '0);
   assign k_done    = (t_ff == k_dim - DIM_W'(1));
   assign row_end   = (j_ff == n_dim - DIM_W'(1));
   assign elem_last = (i_ff == m_dim - DIM_W'(1)) && row_end;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dmm_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (k_dim == '0) ? dmm_pkg::ST_DRAIN : dmm_pkg::ST_READ;
            end
         end
         dmm_pkg::ST_READ: begin
            if (k_done) begin
               state_in = dmm_pkg::ST_DRAIN;
            end
         end
         dmm_pkg::ST_DRAIN: begin
            if (!status.pipe_busy && status.out_free) begin
               if (elem_last) begin
                  state_in = dmm_pkg::ST_IDLE;
               end else begin
                  state_in = (k_dim == '0) ? dmm_pkg::ST_DRAIN : dmm_pkg::ST_READ;
               end
            end
         end
         default: state_in = dmm_pkg::ST_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      cmd       = '0;
      cmd.i     = i_ff;
      cmd.j     = j_ff;
      cmd.t     = t_ff;
      cmd.last  = elem_last;
      i_in      = i_ff;
      j_in      = j_ff;
      t_in      = t_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         dmm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               unique case (dmm_pkg::opcode_type'(req_opcode))
                  dmm_pkg::OP_LOAD_A: begin
                     cmd.wr_a = ({1'b0, req_row} < m_dim) && ({1'b0, req_col} < k_dim);
                  end
                  dmm_pkg::OP_LOAD_B: begin
                     cmd.wr_b = ({1'b0, req_row} < k_dim) && ({1'b0, req_col} < n_dim);
                  end
                  dmm_pkg::OP_MULTIPLY: begin
                     cmd.clr_acc   = 1'b1;
                     cmd.clr_total = 1'b1;
                     i_in = '0;
                     j_in = '0;
                     t_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         dmm_pkg::ST_READ: begin
            cmd.rd_en = 1'b1;
            t_in      = t_ff + DIM_W'(1);
         end
         dmm_pkg::ST_DRAIN: begin
            if (!status.pipe_busy && status.out_free) begin
               cmd.push = 1'b1;
               t_in     = '0;
               if (row_end) begin
                  j_in = '0;
                  i_in = i_ff + DIM_W'(1);
               end else begin
                  j_in = j_ff + DIM_W'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dmm_pkg::ST_IDLE;
         a_rows_ff    <= dmm_pkg::DIM_RESET;
         inner_dim_ff <= dmm_pkg::DIM_RESET;
         b_cols_ff    <= dmm_pkg::DIM_RESET;
         i_ff         <= '0;
         j_ff         <= '0;
         t_ff         <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         t_ff     <= t_in;
         if (csr_write_enable) begin
            unique case (dmm_pkg::csr_reg_type'(csr_index))
               dmm_pkg::REG_A_ROWS:    a_rows_ff    <= csr_data;
               dmm_pkg::REG_INNER_DIM: inner_dim_ff <= csr_data;
               dmm_pkg::REG_B_COLS:    b_cols_ff    <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== rtl/dmm_datapath.sv =====
`timescale 1ns / 1ps
// datapath of the dense matrix multiply unit: element stores, mac pipeline, result register
module dmm_datapath #(
   parameter int unsigned MAX_DIM = dmm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [dmm_pkg::IDX_W-1:0]           req_row,
   input  logic [dmm_pkg::IDX_W-1:0]           req_col,
   input  logic signed [dmm_pkg::VAL_W-1:0]    req_value,
   input  dmm_pkg::cmd_type                    cmd,
   output dmm_pkg::status_type                 status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dmm_pkg::IDX_W-1:0]           rsp_out_row,
   output logic [dmm_pkg::IDX_W-1:0]           rsp_out_col,
   output logic signed [dmm_pkg::ELEM_W-1:0]   rsp_element_value,
   output logic signed [dmm_pkg::SUM_W-1:0]    rsp_total_sum,
   output logic                                rsp_last
);

   localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
   localparam int unsigned AW     = $clog2(DEPTH);
   localparam int unsigned VAL_W  = dmm_pkg::VAL_W;
   localparam int unsigned PROD_W = dmm_pkg::PROD_W;
   localparam int unsigned ELEM_W = dmm_pkg::ELEM_W;
   localparam int unsigned SUM_W  = dmm_pkg::SUM_W;
   localparam int unsigned IDX_W  = dmm_pkg::IDX_W;

   logic [VAL_W-1:0] a_mem_ff [DEPTH];
   logic [VAL_W-1:0] b_mem_ff [DEPTH];

   logic [AW-1:0] wr_addr, a_rd_addr, b_rd_addr;

   logic signed [VAL_W-1:0]  a_rd_ff, b_rd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     rd_vld_ff, prod_vld_ff;
   logic signed [ELEM_W-1:0] acc_ff, acc_in;
   logic signed [SUM_W-1:0]  total_ff, total_in;
   logic signed [SUM_W-1:0]  acc_wide;

   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         out_row_ff, out_col_ff;
   logic signed [ELEM_W-1:0] elem_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic                     last_ff;

   // row-major addressing, row * MAX_DIM + col
   assign wr_addr   = AW'(32'(req_row) * MAX_DIM + 32'(req_col));
   assign a_rd_addr = AW'(32'(cmd.i) * MAX_DIM + 32'(cmd.t));
   assign b_rd_addr = AW'(32'(cmd.t) * MAX_DIM + 32'(cmd.j));

   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         a_mem_ff[wr_addr] <= req_value;
      end
      if (cmd.wr_b) begin
         b_mem_ff[wr_addr] <= req_value;
      end
      if (cmd.rd_en) begin
         a_rd_ff <= a_mem_ff[a_rd_addr];
         b_rd_ff <= b_mem_ff[b_rd_addr];
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      prod_ff <= a_rd_ff * b_rd_ff;
   end

   assign acc_wide = {{(SUM_W-ELEM_W){acc_ff[ELEM_W-1]}}, acc_ff};

   always_comb begin
      acc_in = acc_ff;
      if (cmd.clr_acc || cmd.push) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + {{(ELEM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   always_comb begin
      total_in = total_ff;
      if (cmd.clr_total) begin
         total_in = '0;
      end else if (cmd.push) begin
         total_in = total_ff + acc_wide;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      total_ff <= total_in;
      if (cmd.push) begin
         out_row_ff <= cmd.i[IDX_W-1:0];
         out_col_ff <= cmd.j[IDX_W-1:0];
         elem_ff    <= acc_ff;
         sum_ff     <= cmd.last ? (total_ff + acc_wide) : '0;
         last_ff    <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.rd_en;
         prod_vld_ff <= rd_vld_ff;
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.pipe_busy = rd_vld_ff || prod_vld_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_row       = out_row_ff;
   assign rsp_out_col       = out_col_ff;
   assign rsp_element_value = elem_ff;
   assign rsp_total_sum     = sum_ff;
   assign rsp_last          = last_ff;

endmodule

// ===== rtl/dense_matrix_multiply_unit.sv =====
`timescale 1ns / 1ps
// top level of the dense matrix multiply unit
//
// Multiplies two dense matrices of signed Q8.8 elements and returns C = A*B at full
// Q19.16 precision. Opcode 0 writes one element of A and opcode 1 one element of B
// into stores of MAX_DIM*MAX_DIM entries, addressed row*MAX_DIM+col;
// a load outside the configured a_rows/inner_dim/b_cols bounds is dropped, and
// opcode 3 does nothing. Opcode 2 streams every element of C in row-major order;
// the final response has last set and carries the sum of all elements of C in
// total_sum, which reads zero on every other response. Dimensions above MAX_DIM
// saturate, a zero a_rows or b_cols gives no response, a zero inner_dim gives
// zero elements. Stores power up undefined: only read elements that were loaded.
// Timing: each element of C takes one inner-product step per cycle, set by the
// single read port of each store feeding the one multiplier; its products then
// drain through the read, multiply and accumulate registers before it is handed
// over, and only then does the next element start. A zero inner_dim skips the
// reads. The output register lets the walk go on while a response waits; a stalled
// response holds the walk once the next element is ready. Requests are stalled
// until the whole multiply has been handed over. Configuration registers are to be
// written only while the unit is idle; the unit itself does not enforce this.
module dense_matrix_multiply_unit #(
   parameter int unsigned MAX_DIM = dmm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dmm_pkg::OPC_W-1:0]           req_opcode,
   input  logic [dmm_pkg::IDX_W-1:0]           req_row,
   input  logic [dmm_pkg::IDX_W-1:0]           req_col,
   input  logic signed [dmm_pkg::VAL_W-1:0]    req_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dmm_pkg::IDX_W-1:0]           rsp_out_row,
   output logic [dmm_pkg::IDX_W-1:0]           rsp_out_col,
   output logic signed [dmm_pkg::ELEM_W-1:0]   rsp_element_value,
   output logic signed [dmm_pkg::SUM_W-1:0]    rsp_total_sum,
   output logic                                rsp_last,
   // configuration write port
   input  logic                                csr_write_enable,
   input  logic [dmm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dmm_pkg::CSR_DATA_W-1:0]      csr_data
);

   dmm_pkg::cmd_type    cmd;
   dmm_pkg::status_type status;

   // sequencer: owns the dimension registers and the i/j/t walk
   dmm_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_row          (req_row),
      .req_col          (req_col),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .status           (status)
   );

   // stores, read/multiply/accumulate pipeline and response register
   dmm_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_value         (req_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_element_value (rsp_element_value),
      .rsp_total_sum     (rsp_total_sum),
      .rsp_last          (rsp_last)
   );

   // an element is handed over only after its last product was accumulated
   a_push_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !status.pipe_busy)
      else $error("element pushed with products still in flight");

   // a pushed element always shows up as a response in the next cycle
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> rsp_valid)
      else $error("pushed element not presented");

   // the running sum is only reported on the final element
   a_sum_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_total_sum == '0))
      else $error("total_sum nonzero on a non-final response");

   // stores are never written while a multiply reads them
   a_no_load_in_walk: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (!cmd.wr_a && !cmd.wr_b && req_stall))
      else $error("store write during multiply walk");

endmodule
